/* hdl/sibilance_openness_detector_defines.svh */
// assertion macros for the sibilance openness detector
`ifndef SIBILANCE_OPENNESS_DETECTOR_DEFINES_SVH
`define SIBILANCE_OPENNESS_DETECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during rst
`define SOD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sod assertion failed");
// next-cycle implication, sampled on clk, quiet during rst
`define SOD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sod assertion failed");
`else
`define SOD_ASSERT_IMP(label, pre, post)
`define SOD_ASSERT_NXT(label, pre, post)
`endif
`endif

/* hdl/sod_pkg.sv */
// shared types, constants and register codes of the sibilance openness detector
package sod_pkg;

  // field and state widths
  localparam int ENV_W      = 24;
  localparam int MAG_W      = 16;
  localparam int COEF_W     = 16;
  localparam int RATIO_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // serial multiplier: a operand by b operand, b taken lsb first
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider: remainder and quotient widths
  localparam int DIV_R_W = 24;
  localparam int DIV_Q_W = 16;

  localparam logic [ENV_W-1:0] SILENCE_LEVEL_DEF = 24'd16;
  localparam logic [ENV_W-1:0] ENV_MAX           = 24'hFFFFFF;
  localparam logic [17:0]      SHAPE_THREE       = 18'd196608;
  localparam logic [RATIO_W-1:0] RATIO_MAX       = 16'hFFFF;

  // register values after reset
  localparam logic [COEF_W-1:0] RST_BAND_ATTACK  = 16'd65535;
  localparam logic [COEF_W-1:0] RST_BAND_RELEASE = 16'd1000;
  localparam logic [COEF_W-1:0] RST_FULL_ATTACK  = 16'd5000;
  localparam logic [COEF_W-1:0] RST_FULL_RELEASE = 16'd300;
  localparam logic [COEF_W-1:0] RST_OPEN_ATTACK  = 16'd65535;
  localparam logic [COEF_W-1:0] RST_OPEN_RELEASE = 16'd1500;
  localparam logic [COEF_W-1:0] RST_RATIO_LOW    = 16'd1024;
  localparam logic [COEF_W-1:0] RST_RATIO_HIGH   = 16'd3072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_ATTACK  = 4'd0,
    REG_BAND_RELEASE = 4'd1,
    REG_FULL_ATTACK  = 4'd2,
    REG_FULL_RELEASE = 4'd3,
    REG_OPEN_ATTACK  = 4'd4,
    REG_OPEN_RELEASE = 4'd5,
    REG_RATIO_LOW    = 4'd6,
    REG_RATIO_HIGH   = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [COEF_W-1:0] band_attack;
    logic [COEF_W-1:0] band_release;
    logic [COEF_W-1:0] full_attack;
    logic [COEF_W-1:0] full_release;
    logic [COEF_W-1:0] open_attack;
    logic [COEF_W-1:0] open_release;
    logic [COEF_W-1:0] ratio_low;
    logic [COEF_W-1:0] ratio_high;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_R_W-1:0] rem_init;
    logic [DIV_Q_W-1:0] low_init;
    logic [DIV_R_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_GO,
    ST_ENV_WAIT,
    ST_CHK,
    ST_RAT_GO,
    ST_RAT_WAIT,
    ST_MAP,
    ST_TQ_GO,
    ST_TQ_WAIT,
    ST_TK_GO,
    ST_TK_WAIT,
    ST_MT_GO,
    ST_MT_WAIT,
    ST_OPN_GO,
    ST_OPN_WAIT,
    ST_EMIT
  } state_t;

endpackage

/* hdl/sibilance_openness_detector.sv */
// top level: envelope followers, ratio mapping, smoothstep and openness follower
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//   in        in         in_valid/in_ready      band_magnitude, full_magnitude
//   out       out        out_valid/out_ready    openness_level
//
// an item takes six 16-step passes through the serial multipliers and divider,
// plus accept, check, map and emit steps; a silent item skips the ratio, map and shaping
// passes, a clamped ratio skips the fraction and shaping passes, and a saturated ratio skips the divide.
// reset clears the envelopes and the handshake state and loads the register reset values; ready is low in reset.
// a new item is taken once the previous result sits in the output register;
// a stalled output holds the block in its final step until taken.
`include "sibilance_openness_detector_defines.svh"

module sibilance_openness_detector #(
  parameter logic [sod_pkg::ENV_W-1:0] SILENCE_LEVEL = sod_pkg::SILENCE_LEVEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sod_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sod_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sod_pkg::MAG_W-1:0]         band_magnitude,
  input  logic [sod_pkg::MAG_W-1:0]         full_magnitude,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sod_pkg::MAG_W-1:0]         openness_level
);

  sod_pkg::cfg_t     cfg;
  sod_pkg::state_t   state, state_next;
  sod_pkg::mul_req_t mul0_req, mul1_req;
  sod_pkg::div_req_t div_req;

  logic                          mul0_done, mul1_done, div_done;
  logic [sod_pkg::MUL_P_W-1:0]   mul0_prod, mul1_prod;
  logic [sod_pkg::DIV_Q_W-1:0]   div_quot;

  logic [sod_pkg::ENV_W-1:0]     band_env, full_env, open_env;
  logic [sod_pkg::MAG_W-1:0]     band_mag, full_mag;
  logic [sod_pkg::RATIO_W-1:0]   ratio;
  logic [15:0]                   num_q, den_q, t_q;
  logic [sod_pkg::MUL_A_W-1:0]   m_q;
  logic [sod_pkg::ENV_W-1:0]     raw;

  logic [sod_pkg::ENV_W-1:0]     band_tgt, full_tgt;
  logic [sod_pkg::ENV_W-1:0]     band_diff, full_diff, open_diff;
  logic [sod_pkg::ENV_W-1:0]     step0, step1;
  logic                          band_gt, full_gt, open_gt;
  logic                          full_above, band_sat;
  logic signed [17:0]            num_s, den_s, num_a, den_a;
  logic                          map_zero, map_full;
  logic [17:0]                   shape_k;
  logic                          in_emit;
  logic                          emit_fire;
  logic                          in_mul_wait, in_div_wait;
  logic [3*sod_pkg::ENV_W-1:0]   env_all;

  // register file
  sod_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // shared multiplier for band follower, shaping and openness follower
  sod_serial_mul u_mul0 (
    .clk     (clk),
    .rst     (rst),
    .req     (mul0_req),
    .done    (mul0_done),
    .product (mul0_prod)
  );

  // multiplier for the broadband follower
  sod_serial_mul u_mul1 (
    .clk     (clk),
    .rst     (rst),
    .req     (mul1_req),
    .done    (mul1_done),
    .product (mul1_prod)
  );

  // shared divider for the ratio and the interpolation fraction
  sod_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // follower distances and directions
  assign band_tgt  = {band_mag, 8'h00};
  assign full_tgt  = {full_mag, 8'h00};
  assign band_gt   = band_tgt > band_env;
  assign full_gt   = full_tgt > full_env;
  assign open_gt   = raw > open_env;
  assign band_diff = band_gt ? band_tgt - band_env : band_env - band_tgt;
  assign full_diff = full_gt ? full_tgt - full_env : full_env - full_tgt;
  assign open_diff = open_gt ? raw - open_env : open_env - raw;

  // product shifted right by 16, never larger than the distance
  assign step0 = mul0_prod[39:16];
  assign step1 = mul1_prod[39:16];

  // silence gate and ratio saturation
  assign full_above = full_env > SILENCE_LEVEL;
  assign band_sat   = {4'h0, band_env} >= {full_env, 4'h0};

  // threshold mapping, operands flipped for inverted thresholds
  always_comb begin
    num_s    = $signed({2'b00, ratio}) - $signed({2'b00, cfg.ratio_low});
    den_s    = $signed({2'b00, cfg.ratio_high}) - $signed({2'b00, cfg.ratio_low});
    num_a    = den_s[17] ? -num_s : num_s;
    den_a    = den_s[17] ? -den_s : den_s;
    map_zero = (den_s == '0) || num_a[17] || (num_a == '0);
    map_full = !map_zero && (num_a >= den_a);
  end

  // smoothstep factor 3 - 2t in Q2.16
  assign shape_k = sod_pkg::SHAPE_THREE - {1'b0, t_q, 1'b0};

  assign in_emit   = state == sod_pkg::ST_EMIT;
  assign emit_fire = in_emit && (!out_valid || out_ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sod_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sod_pkg::ST_IDLE:     if (in_valid) state_next = sod_pkg::ST_ENV_GO;
      sod_pkg::ST_ENV_GO:   state_next = sod_pkg::ST_ENV_WAIT;
      sod_pkg::ST_ENV_WAIT: if (mul0_done) state_next = sod_pkg::ST_CHK;
      sod_pkg::ST_CHK: begin
        state_next = full_above ? sod_pkg::ST_RAT_GO : sod_pkg::ST_OPN_GO;
      end
      sod_pkg::ST_RAT_GO: begin
        state_next = band_sat ? sod_pkg::ST_MAP : sod_pkg::ST_RAT_WAIT;
      end
      sod_pkg::ST_RAT_WAIT: if (div_done) state_next = sod_pkg::ST_MAP;
      sod_pkg::ST_MAP: begin
        state_next = (map_zero || map_full) ? sod_pkg::ST_OPN_GO : sod_pkg::ST_TQ_GO;
      end
      sod_pkg::ST_TQ_GO:    state_next = sod_pkg::ST_TQ_WAIT;
      sod_pkg::ST_TQ_WAIT:  if (div_done) state_next = sod_pkg::ST_TK_GO;
      sod_pkg::ST_TK_GO:    state_next = sod_pkg::ST_TK_WAIT;
      sod_pkg::ST_TK_WAIT:  if (mul0_done) state_next = sod_pkg::ST_MT_GO;
      sod_pkg::ST_MT_GO:    state_next = sod_pkg::ST_MT_WAIT;
      sod_pkg::ST_MT_WAIT:  if (mul0_done) state_next = sod_pkg::ST_OPN_GO;
      sod_pkg::ST_OPN_GO:   state_next = sod_pkg::ST_OPN_WAIT;
      sod_pkg::ST_OPN_WAIT: if (mul0_done) state_next = sod_pkg::ST_EMIT;
      sod_pkg::ST_EMIT:     if (emit_fire) state_next = sod_pkg::ST_IDLE;
      default:              state_next = sod_pkg::ST_IDLE;
    endcase
  end

  // unit requests and input handshake
  always_comb begin
    in_ready = 1'b0;
    mul0_req = '0;
    mul1_req = '0;
    div_req  = '0;
    unique case (state)
      sod_pkg::ST_IDLE: in_ready = !rst;
      sod_pkg::ST_ENV_GO: begin
        mul0_req.start = 1'b1;
        mul0_req.a     = {10'h000, band_diff};
        mul0_req.b     = band_gt ? cfg.band_attack : cfg.band_release;
        mul1_req.start = 1'b1;
        mul1_req.a     = {10'h000, full_diff};
        mul1_req.b     = full_gt ? cfg.full_attack : cfg.full_release;
      end
      sod_pkg::ST_RAT_GO: begin
        div_req.start    = !band_sat;
        div_req.rem_init = {4'h0, band_env[23:4]};
        div_req.low_init = {band_env[3:0], 12'h000};
        div_req.divisor  = full_env;
      end
      sod_pkg::ST_TQ_GO: begin
        div_req.start    = 1'b1;
        div_req.rem_init = {8'h00, num_q};
        div_req.low_init = '0;
        div_req.divisor  = {8'h00, den_q};
      end
      sod_pkg::ST_TK_GO: begin
        mul0_req.start = 1'b1;
        mul0_req.a     = {16'h0000, shape_k};
        mul0_req.b     = t_q;
      end
      sod_pkg::ST_MT_GO: begin
        mul0_req.start = 1'b1;
        mul0_req.a     = m_q;
        mul0_req.b     = t_q;
      end
      sod_pkg::ST_OPN_GO: begin
        mul0_req.start = 1'b1;
        mul0_req.a     = {10'h000, open_diff};
        mul0_req.b     = open_gt ? cfg.open_attack : cfg.open_release;
      end
      default: ;
    endcase
  end

  // envelopes and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      band_env  <= '0;
      full_env  <= '0;
      open_env  <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == sod_pkg::ST_ENV_WAIT) && mul0_done) begin
        band_env <= band_gt ? band_env + step0 : band_env - step0;
        full_env <= full_gt ? full_env + step1 : full_env - step1;
      end
      if ((state == sod_pkg::ST_OPN_WAIT) && mul0_done) begin
        open_env <= open_gt ? open_env + step0 : open_env - step0;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and intermediate results
  always_ff @(posedge clk) begin
    if ((state == sod_pkg::ST_IDLE) && in_valid) begin
      band_mag <= band_magnitude;
      full_mag <= full_magnitude;
    end
    if ((state == sod_pkg::ST_CHK) && !full_above) begin
      raw <= '0;
    end
    if ((state == sod_pkg::ST_RAT_GO) && band_sat) begin
      ratio <= sod_pkg::RATIO_MAX;
    end
    if ((state == sod_pkg::ST_RAT_WAIT) && div_done) begin
      ratio <= div_quot;
    end
    if (state == sod_pkg::ST_MAP) begin
      if (map_zero) begin
        raw <= '0;
      end else if (map_full) begin
        raw <= sod_pkg::ENV_MAX;
      end
      num_q <= num_a[15:0];
      den_q <= den_a[15:0];
    end
    if ((state == sod_pkg::ST_TQ_WAIT) && div_done) begin
      t_q <= div_quot;
    end
    if ((state == sod_pkg::ST_TK_WAIT) && mul0_done) begin
      m_q <= mul0_prod[sod_pkg::MUL_A_W-1:0];
    end
    if ((state == sod_pkg::ST_MT_WAIT) && mul0_done) begin
      raw <= (|mul0_prod[49:48]) ? sod_pkg::ENV_MAX : mul0_prod[47:24];
    end
    if (emit_fire) begin
      openness_level <= open_env[23:8];
    end
  end

  // waiting steps and packed envelopes for the checks below
  assign in_mul_wait = (state == sod_pkg::ST_ENV_WAIT) || (state == sod_pkg::ST_TK_WAIT) ||
                       (state == sod_pkg::ST_MT_WAIT) || (state == sod_pkg::ST_OPN_WAIT);
  assign in_div_wait = (state == sod_pkg::ST_RAT_WAIT) || (state == sod_pkg::ST_TQ_WAIT);
  assign env_all     = {band_env, full_env, open_env};

  // multiplier results only arrive in a waiting step
  `SOD_ASSERT_IMP(a_mul_done_in_wait, mul0_done || mul1_done, in_mul_wait)
  // divider results only arrive in a waiting step
  `SOD_ASSERT_IMP(a_div_done_in_wait, div_done, in_div_wait)
  // envelopes do not move while idle
  `SOD_ASSERT_NXT(a_env_hold_idle, state == sod_pkg::ST_IDLE, $stable(env_all))
  // a stalled result keeps the block in its final step
  `SOD_ASSERT_NXT(a_emit_stall, in_emit && out_valid && !out_ready, in_emit && out_valid)

endmodule

/* hdl/sod_cfg_regs.sv */
// configuration register file with write decode and reset values
module sod_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sod_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sod_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sod_pkg::cfg_t                     cfg
);

  // writes are registered, held off during reset
  assign cfg_ready = !rst;

  // register decode, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_attack  <= sod_pkg::RST_BAND_ATTACK;
      cfg.band_release <= sod_pkg::RST_BAND_RELEASE;
      cfg.full_attack  <= sod_pkg::RST_FULL_ATTACK;
      cfg.full_release <= sod_pkg::RST_FULL_RELEASE;
      cfg.open_attack  <= sod_pkg::RST_OPEN_ATTACK;
      cfg.open_release <= sod_pkg::RST_OPEN_RELEASE;
      cfg.ratio_low    <= sod_pkg::RST_RATIO_LOW;
      cfg.ratio_high   <= sod_pkg::RST_RATIO_HIGH;
    end else if (cfg_valid) begin
      unique case (sod_pkg::reg_index_t'(cfg_index))
        sod_pkg::REG_BAND_ATTACK:  cfg.band_attack  <= cfg_data;
        sod_pkg::REG_BAND_RELEASE: cfg.band_release <= cfg_data;
        sod_pkg::REG_FULL_ATTACK:  cfg.full_attack  <= cfg_data;
        sod_pkg::REG_FULL_RELEASE: cfg.full_release <= cfg_data;
        sod_pkg::REG_OPEN_ATTACK:  cfg.open_attack  <= cfg_data;
        sod_pkg::REG_OPEN_RELEASE: cfg.open_release <= cfg_data;
        sod_pkg::REG_RATIO_LOW:    cfg.ratio_low    <= cfg_data;
        sod_pkg::REG_RATIO_HIGH:   cfg.ratio_high   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/sod_serial_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
module sod_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  sod_pkg::mul_req_t             req,
  output logic                          done,
  output logic [sod_pkg::MUL_P_W-1:0]   product
);

  localparam int CNT_W = $clog2(sod_pkg::MUL_B_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [sod_pkg::MUL_A_W-1:0]   aop;
  logic [sod_pkg::MUL_A_W-1:0]   acc;
  logic [sod_pkg::MUL_B_W-1:0]   breg;
  logic [sod_pkg::MUL_A_W:0]     sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, acc} + (breg[0] ? {1'b0, aop} : '0);

  // high half in acc, low half shifted into breg
  assign product = {acc, breg};

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(sod_pkg::MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, sum bit zero drops into the low half
  always_ff @(posedge clk) begin
    if (req.start) begin
      aop  <= req.a;
      acc  <= '0;
      breg <= req.b;
    end else if (busy) begin
      acc  <= sum[sod_pkg::MUL_A_W:1];
      breg <= {sum[0], breg[sod_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

/* hdl/sod_serial_div.sv */
// restoring divider, one quotient bit per cycle
module sod_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  sod_pkg::div_req_t             req,
  output logic                          done,
  output logic [sod_pkg::DIV_Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(sod_pkg::DIV_Q_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [sod_pkg::DIV_R_W-1:0]   rem;
  logic [sod_pkg::DIV_R_W-1:0]   dvs;
  logic [sod_pkg::DIV_Q_W-1:0]   low;
  logic [sod_pkg::DIV_R_W:0]     trial;
  logic [sod_pkg::DIV_R_W:0]     diff;
  logic                          ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, low[sod_pkg::DIV_Q_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  // quotient bits replace dividend bits in the low register
  assign quotient = low;

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(sod_pkg::DIV_Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits the narrow register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      low <= req.low_init;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[sod_pkg::DIV_R_W-1:0] : trial[sod_pkg::DIV_R_W-1:0];
      low <= {low[sod_pkg::DIV_Q_W-2:0], ge};
    end
  end

endmodule
